// File: src/fsp_pkg.sv
// Shared types and constants of the frame sequence player.
// Used by fsp_cfg, fsp_core and frame_sequence_player; depends on nothing.
package fsp_pkg;

    localparam int unsigned MAX_FRAMES = 1024;
    localparam int unsigned FRAME_W    = $clog2(MAX_FRAMES);
    localparam int unsigned COUNT_W    = FRAME_W + 1;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(MAX_FRAMES);
    localparam logic [STEP_W-1:0]  FADE_LEN_RESET    = STEP_W'(24);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN    = CFG_IDX_W'(1);

    typedef enum logic [0:0] {
        CMD_TICK    = 1'b0,
        CMD_SET_SEQ = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        SEQ_CIRCULAR = 2'd0,
        SEQ_FLIPFLOP = 2'd1
    } seq_type_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_START_AFTER   = 2'd1,
        ST_BAD_TYPE      = 2'd2,
        ST_START_BEYOND  = 2'd3
    } status_t;

    typedef struct packed {
        logic [0:0]         command;
        logic [FRAME_W-1:0] req_start;
        logic [COUNT_W-1:0] req_end;
        logic [1:0]         req_type;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic               blend_active;
        logic [STEP_W-1:0]  blend_step;
        logic               blend_restart;
        logic [1:0]         status;
    } out_item_t;

    // Configuration as seen by the sequencer core.
    typedef struct packed {
        logic [COUNT_W-1:0] eff_count;
        logic [STEP_W-1:0]  fade_len;
    } cfg_t;

endpackage

// File: src/fsp_cfg.sv
// Configuration registers of the frame sequence player and the clamped
// frame count derived from them. Depends on fsp_pkg.
module fsp_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output fsp_pkg::cfg_t                      cfg
);

    logic [fsp_pkg::COUNT_W-1:0] frame_count_reg;
    logic [fsp_pkg::STEP_W-1:0]  fade_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= fsp_pkg::FRAME_COUNT_RESET;
            fade_len_reg    <= fsp_pkg::FADE_LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fsp_pkg::REG_FRAME_COUNT: begin
                    frame_count_reg <= cfg_wdata[fsp_pkg::COUNT_W-1:0];
                end
                fsp_pkg::REG_FADE_LEN: begin
                    fade_len_reg <= cfg_wdata[fsp_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Zero acts as one frame; anything above the store size acts as the store size.
    always_comb begin
        if (frame_count_reg > fsp_pkg::COUNT_W'(fsp_pkg::MAX_FRAMES)) begin
            cfg.eff_count = fsp_pkg::COUNT_W'(fsp_pkg::MAX_FRAMES);
        end else if (frame_count_reg == '0) begin
            cfg.eff_count = fsp_pkg::COUNT_W'(1);
        end else begin
            cfg.eff_count = frame_count_reg;
        end
        cfg.fade_len = fade_len_reg;
    end

endmodule

// File: src/fsp_core.sv
// Sequencer state and the single-pass step logic for one item.
// Depends on fsp_pkg.
module fsp_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  fsp_pkg::in_item_t  item,
    input  fsp_pkg::cfg_t      cfg,
    output fsp_pkg::out_item_t result
);

    logic [fsp_pkg::FRAME_W-1:0] current_frame_reg, current_frame_next;
    logic                        backward_reg, backward_next;
    logic                        blending_reg, blending_next;
    logic [fsp_pkg::STEP_W-1:0]  blend_counter_reg, blend_counter_next;
    logic [fsp_pkg::FRAME_W-1:0] seq_first_reg, seq_first_next;
    logic [fsp_pkg::COUNT_W-1:0] seq_last_reg, seq_last_next;
    logic                        flip_mode_reg, flip_mode_next;

    logic [fsp_pkg::STEP_W:0]    counter_inc;
    logic [fsp_pkg::COUNT_W-1:0] cur_wide;
    logic [fsp_pkg::COUNT_W-1:0] step_frame;
    logic                        at_end;
    logic [fsp_pkg::FRAME_W-1:0] wrap_target;
    logic [1:0]                  set_status;

    always_comb begin
        current_frame_next = current_frame_reg;
        backward_next      = backward_reg;
        blending_next      = blending_reg;
        blend_counter_next = blend_counter_reg;
        seq_first_next     = seq_first_reg;
        seq_last_next      = seq_last_reg;
        flip_mode_next     = flip_mode_reg;

        counter_inc = {1'b0, blend_counter_reg} + (fsp_pkg::STEP_W+1)'(1);
        cur_wide    = {1'b0, current_frame_reg};
        step_frame  = '0;
        at_end      = 1'b0;
        wrap_target = (seq_last_reg != '0) ? seq_first_reg : '0;
        set_status  = fsp_pkg::ST_OK;

        result.frame_index   = current_frame_reg;
        result.blend_active  = blending_reg;
        result.blend_step    = blend_counter_reg;
        result.blend_restart = 1'b0;
        result.status        = fsp_pkg::ST_OK;

        if (item.command == fsp_pkg::CMD_SET_SEQ) begin
            // Checks run in priority order; the first failure wins.
            if ({1'b0, item.req_start} > item.req_end) begin
                set_status = fsp_pkg::ST_START_AFTER;
            end else if (item.req_type > fsp_pkg::SEQ_FLIPFLOP) begin
                set_status = fsp_pkg::ST_BAD_TYPE;
            end else if ({1'b0, item.req_start} >= cfg.eff_count) begin
                set_status = fsp_pkg::ST_START_BEYOND;
            end
            result.status = set_status;
            if (set_status == fsp_pkg::ST_OK) begin
                seq_first_next       = item.req_start;
                seq_last_next        = item.req_end;
                flip_mode_next       = (item.req_type == fsp_pkg::SEQ_FLIPFLOP);
                backward_next        = 1'b0;
                blending_next        = 1'b1;
                blend_counter_next   = '0;
                current_frame_next   = item.req_start;
                result.frame_index   = item.req_start;
                result.blend_active  = 1'b1;
                result.blend_step    = '0;
                result.blend_restart = 1'b1;
            end
        end else begin
            if (blending_reg) begin
                if (counter_inc >= {1'b0, cfg.fade_len}) begin
                    blending_next      = 1'b0;
                    blend_counter_next = '0;
                end else begin
                    blend_counter_next = counter_inc[fsp_pkg::STEP_W-1:0];
                end
            end

            if (!backward_reg) begin
                step_frame = cur_wide + fsp_pkg::COUNT_W'(1);
                at_end = (step_frame >= cfg.eff_count) ||
                         ((seq_last_reg != '0) && (step_frame >= seq_last_reg));
            end else if (current_frame_reg == '0) begin
                // Stepping back from frame zero counts as reaching the end.
                step_frame = '0;
                at_end     = 1'b1;
            end else begin
                step_frame = cur_wide - fsp_pkg::COUNT_W'(1);
                at_end = (step_frame < {1'b0, seq_first_reg}) ||
                         (step_frame >= cfg.eff_count);
            end

            if (at_end) begin
                if (flip_mode_reg) begin
                    backward_next = !backward_reg;
                end else begin
                    if (wrap_target != current_frame_reg) begin
                        blending_next        = 1'b1;
                        blend_counter_next   = '0;
                        result.blend_restart = 1'b1;
                    end
                    current_frame_next = wrap_target;
                end
            end else begin
                current_frame_next = step_frame[fsp_pkg::FRAME_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_frame_reg <= '0;
            backward_reg      <= 1'b0;
            blending_reg      <= 1'b0;
            blend_counter_reg <= '0;
            seq_first_reg     <= '0;
            seq_last_reg      <= '0;
            flip_mode_reg     <= 1'b1;
        end else if (step_en) begin
            current_frame_reg <= current_frame_next;
            backward_reg      <= backward_next;
            blending_reg      <= blending_next;
            blend_counter_reg <= blend_counter_next;
            seq_first_reg     <= seq_first_next;
            seq_last_reg      <= seq_last_next;
            flip_mode_reg     <= flip_mode_next;
        end
    end

    // The counter only runs during a cross-fade.
    a_counter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !blending_reg |-> blend_counter_reg == '0)
        else $error("blend counter nonzero outside a cross-fade");

    // A restart always opens a fresh cross-fade.
    a_restart_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.blend_restart |=> blending_reg && blend_counter_reg == '0)
        else $error("restart did not open a cross-fade");

    // An accepted sequence request moves the current frame to its start.
    a_set_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.command == fsp_pkg::CMD_SET_SEQ && result.status == fsp_pkg::ST_OK
        |=> current_frame_reg == $past(item.req_start) && !backward_reg)
        else $error("accepted set did not load the start frame");

    // A rejected request leaves the frame untouched.
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.command == fsp_pkg::CMD_SET_SEQ && result.status != fsp_pkg::ST_OK
        |=> $stable(current_frame_reg))
        else $error("rejected set changed the current frame");

endmodule

// File: src/frame_sequence_player.sv
// Frame sequence player (top level): frame address sequencer for stored animation
// playback. Depends on fsp_pkg, fsp_cfg and fsp_core.
//
// Each transfer on the s_ channel is either a tick, which reports the frame and
// cross-fade state to show now and then advances the sequence, or a set-sequence
// request, which is checked and, if valid, loads a new start, end and mode and
// opens a cross-fade into the start frame. Every input transfer produces exactly
// one result transfer on the m_ channel, in order. The block sustains one item
// per clock cycle while the consumer accepts results: an item is captured in
// an input register, the step logic of the sequencer core evaluates it against
// the sequencer state, and the result lands in an output register while the
// state updates. A result thus passes the input register and then the output
// register before it is offered on the m_ channel. The s_ready signal follows the
// output register's readiness combinationally, so a stalled consumer holds off
// new input after at most the two items already in flight. Configuration
// registers (frame count at index 0, blend duration at index 1) are written
// through cfg_wr_en and should only be changed while no items are in flight.
module frame_sequence_player (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  fsp_pkg::in_item_t              s_data,

    output logic                           m_valid,
    input  logic                           m_ready,
    output fsp_pkg::out_item_t             m_data,

    input  logic                           cfg_wr_en,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic               in_valid_reg;
    fsp_pkg::in_item_t  in_data_reg;
    logic               out_valid_reg;
    fsp_pkg::out_item_t out_data_reg;

    logic               advance;
    fsp_pkg::cfg_t      cfg;
    fsp_pkg::out_item_t step_result;

    // The held item moves to the output register whenever that slot is free
    // or is being emptied in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    fsp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    // A captured input item always reaches the input register.
    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted transfer was not captured");

    // A stepped item always yields a pending result.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("stepped item produced no result");

    // The step never runs while the output slot is occupied and stalled.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule
